FILE: design/hrld_pkg.sv
// hrld_pkg: shared types, constants and helper functions for the hex record line decoder
// no dependencies; used by hex_record_line_decoder, hrld_checker and the testbench

package hrld_pkg;

  // field widths
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned STATUS_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [BYTE_W-1:0]  SUM_GOOD  = 8'hFF;

  // stream packing, lowest bit first
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam int unsigned OD_VALUE_LO  = 0;
  localparam int unsigned OD_INDEX_LO  = OD_VALUE_LO + BYTE_W;
  localparam int unsigned OD_STATUS_LO = OD_INDEX_LO + COUNT_W;
  localparam int unsigned OD_USED_W    = OD_STATUS_LO + STATUS_W;

  localparam int unsigned OU_KIND   = 0;
  localparam int unsigned OU_HEADER = 1;

  // ascii digit bounds
  localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_F = 8'h46;
  localparam logic [NIB_W-1:0]  NIB_TEN = 4'd10;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_BAD_SUM   = 2'd2,
    ST_TOO_SHORT = 2'd3
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  byte_value;
    logic [COUNT_W-1:0] byte_index;
    logic               is_header;
    status_t            status;
    logic               line_done;
  } result_t;

  typedef struct packed {
    logic             bad;
    logic [NIB_W-1:0] value;
  } nibble_t;

  // uppercase hex digit to nibble; anything else flagged bad with value zero
  function automatic nibble_t hex_value(input logic [CHAR_W-1:0] c);
    nibble_t n;
    logic [CHAR_W-1:0] d_num;
    logic [CHAR_W-1:0] d_alpha;
    d_num   = c - CH_0;
    d_alpha = c - CH_A;
    n.bad   = 1'b0;
    n.value = '0;
    if (c >= CH_0 && c <= CH_9) begin
      n.value = d_num[NIB_W-1:0];
    end else if (c >= CH_A && c <= CH_F) begin
      n.value = d_alpha[NIB_W-1:0] + NIB_TEN;
    end else begin
      n.bad = 1'b1;
    end
    return n;
  endfunction

endpackage

FILE: design/hex_record_line_decoder.sv
// hex_record_line_decoder: top level, ascii hex record line to byte stream plus line status
// depends on hrld_pkg (types, constants, hex_value)

// Takes one character per request on the in_ stream; in_tlast marks the end
// character of a line, which is not decoded itself. The first character of
// each line is skipped, the rest pair into uppercase hex bytes, high nibble
// first. Every decoded byte is emitted one byte late (kind = data), so the
// last byte of the line, the checksum, never appears. The end character
// produces one status result (kind = status, out_tlast high) carrying the
// byte count and status: bad digit over too short (fewer than HEADER_BYTES
// bytes) over bad checksum (byte sum not 0xFF) over ok; line state then
// clears. Throughput is one character per clock unless out_tready stalls:
// a character goes into an input register, is decoded by a few gates
// against the line state, and its result lands in an output register.
// A stall on out_tready holds the input only once a character that
// produces a result sits in the input register with the output register
// full; characters without a result keep flowing until then.

module hex_record_line_decoder #(
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input characters
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hrld_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_code
  input  logic                             in_tlast,   // end_of_line
  // results
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hrld_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] byte_value, [24:8] byte_index,
                                                       // [26:25] status, [31:27] zero
  output logic                             out_tlast,  // line_done
  output logic [hrld_pkg::OUT_TUSER_W-1:0] out_tuser   // [0] kind, [1] is_header
);

  localparam logic [hrld_pkg::COUNT_W-1:0] HDR_CNT = hrld_pkg::COUNT_W'(HEADER_BYTES);

  // input register
  logic                          s1_valid_r, s1_valid_nxt;
  logic [hrld_pkg::CHAR_W-1:0]   s1_char_r;
  logic                          s1_eol_r;

  // line state
  logic                          skip_first_r,   skip_first_nxt;
  logic                          nibble_phase_r, nibble_phase_nxt;
  logic [hrld_pkg::NIB_W-1:0]    high_nibble_r,  high_nibble_nxt;
  logic [hrld_pkg::BYTE_W-1:0]   held_byte_r,    held_byte_nxt;
  logic                          held_valid_r,   held_valid_nxt;
  logic [hrld_pkg::COUNT_W-1:0]  byte_count_r,   byte_count_nxt;
  logic [hrld_pkg::BYTE_W-1:0]   running_sum_r,  running_sum_nxt;
  logic                          digit_error_r,  digit_error_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  hrld_pkg::result_t             out_res_r,   out_res_nxt;

  // decode signals
  hrld_pkg::nibble_t             nib;
  hrld_pkg::result_t             res;
  hrld_pkg::status_t             line_status;
  logic                          produces;
  logic                          out_free;
  logic                          s1_consume;
  logic [hrld_pkg::BYTE_W-1:0]   new_byte;
  logic [hrld_pkg::COUNT_W-1:0]  held_idx;

  assign out_free   = !out_valid_r || out_tready;
  assign s1_consume = s1_valid_r && (!produces || out_free);
  assign in_tready  = !s1_valid_r || s1_consume;

  assign nib      = hrld_pkg::hex_value(s1_char_r);
  assign new_byte = {high_nibble_r, nib.value};
  assign held_idx = byte_count_r - hrld_pkg::COUNT_W'(1);

  // status priority: bad digit, too short, bad checksum
  always_comb begin
    if (digit_error_r) begin
      line_status = hrld_pkg::ST_BAD_DIGIT;
    end else if (byte_count_r < HDR_CNT) begin
      line_status = hrld_pkg::ST_TOO_SHORT;
    end else if (running_sum_r != hrld_pkg::SUM_GOOD) begin
      line_status = hrld_pkg::ST_BAD_SUM;
    end else begin
      line_status = hrld_pkg::ST_OK;
    end
  end

  // per-character decode against the line state
  always_comb begin
    skip_first_nxt   = skip_first_r;
    nibble_phase_nxt = nibble_phase_r;
    high_nibble_nxt  = high_nibble_r;
    held_byte_nxt    = held_byte_r;
    held_valid_nxt   = held_valid_r;
    byte_count_nxt   = byte_count_r;
    running_sum_nxt  = running_sum_r;
    digit_error_nxt  = digit_error_r;
    produces         = 1'b0;
    res              = '0;

    if (s1_eol_r) begin
      // end character: report and clear the line
      produces         = 1'b1;
      res.kind         = hrld_pkg::KIND_STATUS;
      res.byte_index   = byte_count_r;
      res.status       = line_status;
      res.line_done    = 1'b1;
      skip_first_nxt   = 1'b1;
      nibble_phase_nxt = 1'b0;
      high_nibble_nxt  = '0;
      held_byte_nxt    = '0;
      held_valid_nxt   = 1'b0;
      byte_count_nxt   = '0;
      running_sum_nxt  = '0;
      digit_error_nxt  = 1'b0;
    end else if (skip_first_r) begin
      skip_first_nxt = 1'b0;
    end else begin
      if (nib.bad) begin
        digit_error_nxt = 1'b1;
      end
      if (!nibble_phase_r) begin
        high_nibble_nxt  = nib.value;
        nibble_phase_nxt = 1'b1;
      end else begin
        nibble_phase_nxt = 1'b0;
        // previous byte goes out now that another one follows it
        if (held_valid_r) begin
          produces       = 1'b1;
          res.kind       = hrld_pkg::KIND_DATA;
          res.byte_value = held_byte_r;
          res.byte_index = held_idx;
          res.is_header  = held_idx < HDR_CNT;
        end
        held_byte_nxt   = new_byte;
        held_valid_nxt  = 1'b1;
        running_sum_nxt = running_sum_r + new_byte;
        if (byte_count_r != hrld_pkg::COUNT_MAX) begin
          byte_count_nxt = byte_count_r + hrld_pkg::COUNT_W'(1);
        end
      end
    end
  end

  // output register and input register handshakes
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_consume && produces) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
    s1_valid_nxt = s1_valid_r;
    if (s1_consume) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      skip_first_r   <= 1'b1;
      nibble_phase_r <= 1'b0;
      high_nibble_r  <= '0;
      held_byte_r    <= '0;
      held_valid_r   <= 1'b0;
      byte_count_r   <= '0;
      running_sum_r  <= '0;
      digit_error_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_consume) begin
        skip_first_r   <= skip_first_nxt;
        nibble_phase_r <= nibble_phase_nxt;
        high_nibble_r  <= high_nibble_nxt;
        held_byte_r    <= held_byte_nxt;
        held_valid_r   <= held_valid_nxt;
        byte_count_r   <= byte_count_nxt;
        running_sum_r  <= running_sum_nxt;
        digit_error_r  <= digit_error_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata[hrld_pkg::CHAR_W-1:0];
      s1_eol_r  <= in_tlast;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.line_done;
  assign out_tdata  = {(hrld_pkg::OUT_TDATA_W - hrld_pkg::OD_USED_W)'(0),
                       out_res_r.status, out_res_r.byte_index, out_res_r.byte_value};
  assign out_tuser  = {out_res_r.is_header, out_res_r.kind};

endmodule

FILE: design/hrld_checker.sv
// hrld_checker: port-level assertions for hex_record_line_decoder, with its bind
// depends on hrld_pkg (field positions and codes)

module hrld_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hrld_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast,
  input logic [hrld_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // line_done goes with status results only
  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser[hrld_pkg::OU_KIND] == hrld_pkg::KIND_STATUS)))
    else $error("line_done does not match kind");

  // data results carry ok status
  a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[hrld_pkg::OU_KIND] == hrld_pkg::KIND_DATA |->
      out_tdata[hrld_pkg::OD_STATUS_LO +: hrld_pkg::STATUS_W] == hrld_pkg::ST_OK)
    else $error("data result with nonzero status");

  // status results carry no byte and no header flag
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[hrld_pkg::OU_KIND] == hrld_pkg::KIND_STATUS |->
      out_tdata[hrld_pkg::OD_VALUE_LO +: hrld_pkg::BYTE_W] == '0
      && !out_tuser[hrld_pkg::OU_HEADER])
    else $error("status result with byte payload");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind hex_record_line_decoder hrld_checker u_hrld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

FILE: verif/hex_record_line_decoder_tb.sv
`timescale 1ns / 1ps
// hex_record_line_decoder_tb: self-checking bench for the hex record line decoder
// sends character requests, predicts decoded bytes and line status, checks each result
// depends on hrld_pkg and hex_record_line_decoder

module hex_record_line_decoder_tb;

  localparam int unsigned HDR_BYTES    = 8;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PRINT_CAP    = 50;

  localparam logic [hrld_pkg::CHAR_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [hrld_pkg::CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [hrld_pkg::CHAR_W-1:0] CH_LOWER_A = 8'h61;

  // one row of the directed table; want is only used where typed is set
  typedef struct {
    logic [hrld_pkg::CHAR_W-1:0] ch;
    logic                        last;
    bit                          typed;
    hrld_pkg::result_t           want;
  } dir_row_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [hrld_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             in_tlast   = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [hrld_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;
  logic [hrld_pkg::OUT_TUSER_W-1:0] out_tuser;

  // idle odds in percent, changed per phase by the stimulus
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned chars_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;

  // results the decoder still owes, oldest first
  hrld_pkg::result_t line_outputs_due[$];

  // predictor copy of the line state
  logic                         first_pending  = 1'b1;
  logic                         hi_waiting     = 1'b0;
  logic [hrld_pkg::NIB_W-1:0]   hi_nib         = '0;
  logic [hrld_pkg::BYTE_W-1:0]  pend_byte      = '0;
  logic                         pend_valid     = 1'b0;
  logic [hrld_pkg::COUNT_W-1:0] line_bytes     = '0;
  logic [hrld_pkg::BYTE_W-1:0]  line_sum       = '0;
  logic                         line_bad_digit = 1'b0;

  hex_record_line_decoder #(
    .HEADER_BYTES(HDR_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the decoder hangs or swallows a result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch in %s: got 0x%0h, want 0x%0h at result %0d",
               what, got, want, results_seen);
    end
    mismatches++;
  endtask

  // advance the line state by one character; returns 1 when a result is due
  function automatic bit decode_char(input logic [hrld_pkg::CHAR_W-1:0] ch, input logic last,
                                     output hrld_pkg::result_t r);
    logic [hrld_pkg::NIB_W-1:0]   nib;
    logic [hrld_pkg::BYTE_W-1:0]  b;
    logic [hrld_pkg::COUNT_W-1:0] idx;
    bit                           has;
    r   = '0;
    has = 1'b0;
    if (last) begin
      // end character: status only, its own code is ignored
      r.kind       = hrld_pkg::KIND_STATUS;
      r.byte_index = line_bytes;
      r.line_done  = 1'b1;
      if (line_bad_digit) begin
        r.status = hrld_pkg::ST_BAD_DIGIT;
      end else if (line_bytes < HDR_BYTES) begin
        r.status = hrld_pkg::ST_TOO_SHORT;
      end else if (line_sum != hrld_pkg::SUM_GOOD) begin
        r.status = hrld_pkg::ST_BAD_SUM;
      end else begin
        r.status = hrld_pkg::ST_OK;
      end
      first_pending  = 1'b1;
      hi_waiting     = 1'b0;
      hi_nib         = '0;
      pend_byte      = '0;
      pend_valid     = 1'b0;
      line_bytes     = '0;
      line_sum       = '0;
      line_bad_digit = 1'b0;
      return 1'b1;
    end
    if (first_pending) begin
      first_pending = 1'b0;
      return 1'b0;
    end
    // digits keep their value in the low nibble, letters A-F sit nine below theirs
    if (ch >= hrld_pkg::CH_0 && ch <= hrld_pkg::CH_9) begin
      nib = ch[hrld_pkg::NIB_W-1:0];
    end else if (ch >= hrld_pkg::CH_A && ch <= hrld_pkg::CH_F) begin
      nib = ch[hrld_pkg::NIB_W-1:0] + 4'd9;
    end else begin
      nib            = '0;
      line_bad_digit = 1'b1;
    end
    if (!hi_waiting) begin
      hi_nib     = nib;
      hi_waiting = 1'b1;
      return 1'b0;
    end
    hi_waiting = 1'b0;
    b          = {hi_nib, nib};
    // the byte before this one goes out now
    if (pend_valid) begin
      idx          = line_bytes - 1'b1;
      r.kind       = hrld_pkg::KIND_DATA;
      r.byte_value = pend_byte;
      r.byte_index = idx;
      r.is_header  = (idx < HDR_BYTES);
      has          = 1'b1;
    end
    pend_byte  = b;
    pend_valid = 1'b1;
    line_sum   = line_sum + b;
    if (line_bytes != hrld_pkg::COUNT_MAX) begin
      line_bytes = line_bytes + 1'b1;
    end
    return has;
  endfunction

  function automatic logic [hrld_pkg::CHAR_W-1:0] hex_char(input logic [hrld_pkg::NIB_W-1:0] n);
    return (n < 4'd10) ? hrld_pkg::CH_0 + n : hrld_pkg::CH_A + (n - 4'd10);
  endfunction

  // mix of valid digits, lowercase letters and arbitrary codes
  function automatic logic [hrld_pkg::CHAR_W-1:0] noise_char();
    case ($urandom_range(2))
      0:       return hex_char(4'($urandom));
      1:       return CH_LOWER_A + 8'($urandom_range(5));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic hrld_pkg::result_t status_result(input logic [hrld_pkg::COUNT_W-1:0] count,
                                                      input hrld_pkg::status_t st);
    hrld_pkg::result_t r;
    r            = '0;
    r.kind       = hrld_pkg::KIND_STATUS;
    r.byte_index = count;
    r.status     = st;
    r.line_done  = 1'b1;
    return r;
  endfunction

  // one character request: random idle gaps, wait for acceptance, then predict
  task automatic send_char(input logic [hrld_pkg::CHAR_W-1:0] ch, input logic last,
                           input bit typed, input hrld_pkg::result_t want);
    hrld_pkg::result_t r;
    bit                has;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    has = decode_char(ch, last, r);
    if (typed) begin
      line_outputs_due.push_back(want);
    end else if (has) begin
      line_outputs_due.push_back(r);
    end
    chars_sent++;
  endtask

  // mostly well-formed records with random bytes, some corrupted, some plain noise
  task automatic send_random_line();
    logic [hrld_pkg::CHAR_W-1:0] chars[$];
    logic [hrld_pkg::BYTE_W-1:0] sum;
    logic [hrld_pkg::BYTE_W-1:0] b;
    int                          n;
    sum = '0;
    if ($urandom_range(99) < 75) begin
      chars.push_back(($urandom_range(3) == 0) ? 8'($urandom) : CH_COLON);
      // mostly long enough to pass the header length, a few too short
      n = ($urandom_range(3) == 0) ? $urandom_range(6) : $urandom_range(12, 7);
      for (int i = 0; i <= n; i++) begin
        if (i < n) begin
          b   = 8'($urandom);
          sum = sum + b;
        end else begin
          // checksum, right most of the time
          b = ($urandom_range(3) == 0) ? 8'($urandom) : hrld_pkg::SUM_GOOD - sum;
        end
        chars.push_back(hex_char(b[7:4]));
        chars.push_back(hex_char(b[3:0]));
      end
      // noise character, often a bad digit, somewhere past the first character
      if ($urandom_range(9) == 0) begin
        chars[$urandom_range(chars.size() - 1, 1)] = noise_char();
      end
      // dropped character leaves a half pair
      if ($urandom_range(9) == 0) begin
        chars.delete($urandom_range(chars.size() - 1, 1));
      end
    end else begin
      n = $urandom_range(16);
      repeat (n) chars.push_back(noise_char());
    end
    foreach (chars[i]) send_char(chars[i], 1'b0, 1'b0, '0);
    send_char(($urandom_range(1) == 1) ? CH_LF : 8'($urandom), 1'b1, 1'b0, '0);
  endtask

  // result side: random stalls, each accepted result checked against the oldest due one
  always @(posedge clk) begin : result_monitor
    hrld_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (line_outputs_due.size() == 0) begin
        report_mismatch("result with nothing due", out_tdata, 0);
      end else begin
        want = line_outputs_due.pop_front();
        if (out_tuser[hrld_pkg::OU_KIND] !== want.kind)
          report_mismatch("kind", out_tuser[hrld_pkg::OU_KIND], want.kind);
        if (out_tdata[hrld_pkg::OD_VALUE_LO +: hrld_pkg::BYTE_W] !== want.byte_value)
          report_mismatch("byte_value", out_tdata[hrld_pkg::OD_VALUE_LO +: hrld_pkg::BYTE_W],
                          want.byte_value);
        if (out_tdata[hrld_pkg::OD_INDEX_LO +: hrld_pkg::COUNT_W] !== want.byte_index)
          report_mismatch("byte_index", out_tdata[hrld_pkg::OD_INDEX_LO +: hrld_pkg::COUNT_W],
                          want.byte_index);
        if (out_tuser[hrld_pkg::OU_HEADER] !== want.is_header)
          report_mismatch("is_header", out_tuser[hrld_pkg::OU_HEADER], want.is_header);
        if (out_tdata[hrld_pkg::OD_STATUS_LO +: hrld_pkg::STATUS_W] !== want.status)
          report_mismatch("status", out_tdata[hrld_pkg::OD_STATUS_LO +: hrld_pkg::STATUS_W],
                          want.status);
        if (out_tlast !== want.line_done)
          report_mismatch("line_done", out_tlast, want.line_done);
        // padding above the status field stays zero
        if (out_tdata[hrld_pkg::OUT_TDATA_W-1:hrld_pkg::OD_USED_W] !== '0)
          report_mismatch("tdata padding",
                          out_tdata[hrld_pkg::OUT_TDATA_W-1:hrld_pkg::OD_USED_W], 0);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin : stimulus
    dir_row_t dir_rows[$];
    string    good_line;
    // seven bytes plus checksum 4D, sum 0xFF
    good_line = "A509F0123456784D";

    // empty line right after reset, end character at the top code
    dir_rows.push_back('{8'hFF, 1'b1, 1'b1,
                         status_result(hrld_pkg::COUNT_W'(0), hrld_pkg::ST_TOO_SHORT)});
    // zero code skipped as first character, lowercase digit, then a half pair
    dir_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    dir_rows.push_back('{CH_LOWER_A, 1'b0, 1'b0, '0});
    dir_rows.push_back('{hrld_pkg::CH_F, 1'b0, 1'b0, '0});
    dir_rows.push_back('{hrld_pkg::CH_9, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b1, 1'b1,
                         status_result(hrld_pkg::COUNT_W'(1), hrld_pkg::ST_BAD_DIGIT)});
    // minimal good record: header length reached, checksum right
    dir_rows.push_back('{CH_COLON, 1'b0, 1'b0, '0});
    for (int i = 0; i < good_line.len(); i++) begin
      dir_rows.push_back('{good_line[i], 1'b0, 1'b0, '0});
    end
    dir_rows.push_back('{CH_LF, 1'b1, 1'b1,
                         status_result(hrld_pkg::COUNT_W'(HDR_BYTES), hrld_pkg::ST_OK)});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles more rarely than the receiver
    send_idle_pct = 35;
    recv_idle_pct = 64;
    foreach (dir_rows[i]) send_char(dir_rows[i].ch, dir_rows[i].last,
                                    dir_rows[i].typed, dir_rows[i].want);
    while (chars_sent < 160) send_random_line();

    // roles swapped
    send_idle_pct = 64;
    recv_idle_pct = 35;
    while (chars_sent < 290) send_random_line();

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (chars_sent < 400) send_random_line();

    in_tvalid <= 1'b0;
    while (line_outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/hrld_pkg.sv
design/hex_record_line_decoder.sv
design/hrld_checker.sv
verif/hex_record_line_decoder_tb.sv
